@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define SHS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/shs_pkg.sv @@
// shared types, constants and round constant table of the sha-256 hasher
// no dependencies
package shs_pkg;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_LENBLK,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUTPUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic       write_byte;
        logic       pad;
        logic       zero_blk;
        logic       insert_len;
        logic       load;
        logic       round;
        logic       update;
        logic       restart;
        logic [5:0] round_idx;
        logic [2:0] word_sel;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic fill_last;
        logic fill_hi;
    } t_stat;

    function automatic logic [31:0] start_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/shs_ctrl.sv @@
// sequencing state machine of the sha-256 hasher
// depends on shs_pkg
module shs_ctrl
    import shs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_has_byte,
    input  logic       i_end_of_message,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_word_index,
    output logic       o_last_word,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [2:0] r_word, n_word;
    logic       r_eom_pend, n_eom_pend;
    logic       r_need_len, n_need_len;
    logic       r_final, n_final;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_COLLECT;
            r_round    <= '0;
            r_word     <= '0;
            r_eom_pend <= 1'b0;
            r_need_len <= 1'b0;
            r_final    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_word     <= n_word;
            r_eom_pend <= n_eom_pend;
            r_need_len <= n_need_len;
            r_final    <= n_final;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_word     = r_word;
        n_eom_pend = r_eom_pend;
        n_need_len = r_need_len;
        n_final    = r_final;
        o_cmd      = '0;
        o_cmd.round_idx = r_round;
        o_cmd.word_sel  = r_word;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.write_byte = i_has_byte;
                    if (i_has_byte && i_stat.fill_last) begin
                        n_eom_pend = i_end_of_message;
                        n_state    = ST_LOAD;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.pad  = 1'b1;
                n_eom_pend = 1'b0;
                if (i_stat.fill_hi) begin
                    n_need_len = 1'b1;
                end else begin
                    o_cmd.insert_len = 1'b1;
                    n_final          = 1'b1;
                end
                n_state = ST_LOAD;
            end
            ST_LENBLK: begin
                o_cmd.zero_blk   = 1'b1;
                o_cmd.insert_len = 1'b1;
                n_need_len       = 1'b0;
                n_final          = 1'b1;
                n_state          = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_round    = '0;
                n_state    = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (r_final) begin
                    n_word  = '0;
                    n_state = ST_OUTPUT;
                end else if (r_need_len) begin
                    n_state = ST_LENBLK;
                end else if (r_eom_pend) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_COLLECT;
                end
            end
            ST_OUTPUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (r_word == LAST_WORD) begin
                        o_cmd.restart = 1'b1;
                        n_final       = 1'b0;
                        n_word        = '0;
                        n_state       = ST_COLLECT;
                    end else begin
                        n_word = r_word + 3'd1;
                    end
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    assign o_word_index = r_word;
    assign o_last_word  = (r_word == LAST_WORD);

endmodule

@@ rtl/shs_datapath.sv @@
// block buffer, message schedule, round logic and chaining words of the sha-256 hasher
// depends on shs_pkg
module shs_datapath
    import shs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_stat       o_stat,
    output logic [31:0] o_digest_word
);

    logic [31:0] r_hash [8];
    logic [31:0] r_s    [8];
    logic [31:0] r_w    [16];
    logic [63:0] r_total;
    logic [5:0]  r_fill;

    logic [31:0] t1, t2, w_new, sig_e, sig_a, ch, maj, ls0, ls1;
    logic [63:0] len_bits;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // round and schedule logic
    always_comb begin
        sig_e = rotr(r_s[4], 6) ^ rotr(r_s[4], 11) ^ rotr(r_s[4], 25);
        sig_a = rotr(r_s[0], 2) ^ rotr(r_s[0], 13) ^ rotr(r_s[0], 22);
        ch    = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
        maj   = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);
        t1    = r_s[7] + sig_e + ch + round_k(i_cmd.round_idx) + r_w[0];
        t2    = sig_a + maj;
        ls0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        ls1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + ls0 + r_w[9] + ls1;
        len_bits = {r_total[60:0], 3'b000};
    end

    // chaining words, byte count and fill position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= start_word(3'(i));
            end
            r_total <= '0;
            r_fill  <= '0;
        end else begin
            if (i_cmd.write_byte) begin
                r_total <= r_total + 64'd1;
                r_fill  <= r_fill + 6'd1;
            end
            if (i_cmd.update) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_s[i];
                end
            end
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 8; i++) begin
                r_s[i] <= r_hash[i];
            end
        end else if (i_cmd.round) begin
            r_s[0] <= t1 + t2;
            r_s[1] <= r_s[0];
            r_s[2] <= r_s[1];
            r_s[3] <= r_s[2];
            r_s[4] <= r_s[3] + t1;
            r_s[5] <= r_s[4];
            r_s[6] <= r_s[5];
            r_s[7] <= r_s[6];
        end
    end

    // block buffer, doubling as the schedule window during rounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_byte) begin
            r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_data_byte;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end else if (i_cmd.pad || i_cmd.zero_blk) begin
            for (int i = 0; i < 16; i++) begin
                // the last two words take the bit length when it goes in
                if (i_cmd.insert_len && i >= 14) begin
                    r_w[i] <= (i == 14) ? len_bits[63:32] : len_bits[31:0];
                end else begin
                    for (int j = 0; j < 4; j++) begin
                        if (i_cmd.zero_blk || 6'(i*4 + j) > r_fill) begin
                            r_w[i][8*(3-j) +: 8] <= 8'h00;
                        end else if (6'(i*4 + j) == r_fill) begin
                            r_w[i][8*(3-j) +: 8] <= PAD_MARK;
                        end
                    end
                end
            end
        end
    end

    assign o_stat.fill_last = (r_fill == LAST_BYTE);
    assign o_stat.fill_hi   = (r_fill >= LEN_POS);
    assign o_digest_word    = r_hash[i_cmd.word_sel];

endmodule

@@ rtl/sha256_stream_hasher_core.sv @@
// top level of the sha-256 stream hasher
// depends on shs_pkg, shs_ctrl and shs_datapath
//
// Input channel (i_valid / o_stall): one item per transfer, carrying an optional
// message byte (i_has_byte) and an end-of-message mark. While bytes are being
// gathered the block takes one item per cycle. The transfer that completes a
// 64-byte block stalls the input through a load state, 64 rounds in the single
// shared round unit, and an update state that folds into the chaining words.
// End of message costs a pad state plus a load, rounds and update per final block
// (one or two blocks, two when 56 or more bytes of the last block are used),
// after which the eight digest words appear on the output channel (o_valid /
// i_stall), word 0 first, with o_last_word on word 7. Input stays stalled until
// all eight words have transferred; the digest state then restarts at once.
// A stalled output word holds steady. Reset (synchronous) loads the initial hash
// values, clears byte count and fill position and returns to gathering bytes.
module sha256_stream_hasher_core
    import shs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    shs_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word),
        .i_stat           (stat),
        .o_cmd            (cmd)
    );

    // hashing datapath
    shs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_stat        (stat),
        .o_digest_word (o_digest_word)
    );

endmodule

@@ rtl/shs_checker.sv @@
// port-level checks of the sha-256 stream hasher, bound to the top level
// depends on assert_macros.svh and shs_pkg
`include "assert_macros.svh"
module shs_checker
    import shs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_end_of_message,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // no input transfer while the digest is being delivered
    `SHS_ASSERT(a_stall_on_out, i_clk, i_rst_n, o_valid |-> o_stall, "input open during digest")

    // end of message holds off the input on the next cycle
    `SHS_ASSERT(a_eom_stall, i_clk, i_rst_n,
        (i_valid && !o_stall && i_end_of_message) |=> o_stall,
        "input open after end of message")

    // last word flag marks word 7 only
    `SHS_ASSERT(a_last_flag, i_clk, i_rst_n,
        o_valid |-> (o_last_word == (o_word_index == LAST_WORD)),
        "last word flag mismatch")

    // digest words step in order
    `SHS_ASSERT(a_word_step, i_clk, i_rst_n,
        (o_valid && !i_stall && !o_last_word) |=>
            (o_valid && (o_word_index == 3'($past(o_word_index) + 3'd1))),
        "digest word out of order")

    // stalled output word holds
    `SHS_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_digest_word) && $stable(o_word_index)),
        "stalled digest word changed")

endmodule

bind sha256_stream_hasher_core shs_checker u_shs_checker (.*);
